[rtl/core/int_to_decimal_ascii_assert.svh]
// ----------------------------------------------------------------------------
// int_to_decimal_ascii assertion macros
// Shared property templates for the converter checks, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication
`define I2DA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/i2da_pkg.sv]
// ----------------------------------------------------------------------------
// i2da_pkg
// Types and constants shared by the decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  localparam logic [3:0] BCD_LIMIT = 4'd5;
  localparam logic [3:0] BCD_CORR  = 4'd3;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_SHIFT,
    CV_DONE
  } conv_state_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SIGN,
    EM_SKIP,
    EM_DIGIT
  } emit_state_t;

  typedef struct packed {
    logic valid;
    logic negative;
  } conv_res_t;

endpackage

[rtl/core/i2da_in_if.sv]
// ----------------------------------------------------------------------------
// i2da_in_if
// Input channel: one signed integer per transaction.
// ----------------------------------------------------------------------------
interface i2da_in_if #(
  parameter int WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/core/i2da_out_if.sv]
// ----------------------------------------------------------------------------
// i2da_out_if
// Result channel: one ASCII character per transaction.
// ----------------------------------------------------------------------------
interface i2da_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

[rtl/core/i2da_bcd_conv.sv]
// ----------------------------------------------------------------------------
// i2da_bcd_conv
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit
// per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module i2da_bcd_conv
  import i2da_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int NUM_DIGITS  = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [VALUE_WIDTH-1:0]  value,
  output conv_res_t               res,
  output logic [4*NUM_DIGITS-1:0] bcd,
  input  logic                    take
);

  localparam int BCD_W = 4 * NUM_DIGITS;
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  conv_state_t            state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       adj;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CV_IDLE:  if (in_valid) state_nxt = CV_SHIFT;
      CV_SHIFT: if (cnt_r == '0) state_nxt = CV_DONE;
      CV_DONE:  if (take) state_nxt = CV_IDLE;
      default:  state_nxt = CV_IDLE;
    endcase
  end

  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      adj[4*d +: 4] = (bcd_r[4*d +: 4] >= BCD_LIMIT) ? bcd_r[4*d +: 4] + BCD_CORR
                                                     : bcd_r[4*d +: 4];
    end
  end

  always_comb begin
    in_ready     = 1'b0;
    res.valid    = 1'b0;
    res.negative = neg_r;
    mag_nxt      = mag_r;
    bcd_nxt      = bcd_r;
    cnt_nxt      = cnt_r;
    neg_nxt      = neg_r;
    case (state_r)
      CV_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          neg_nxt = value[VALUE_WIDTH-1];
          mag_nxt = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
          bcd_nxt = '0;
          cnt_nxt = CNT_W'(VALUE_WIDTH - 1);
        end
      end
      CV_SHIFT: begin
        mag_nxt = mag_r << 1;
        bcd_nxt = {adj[BCD_W-2:0], mag_r[VALUE_WIDTH-1]};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      CV_DONE: begin
        res.valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign bcd = bcd_r;

endmodule

[rtl/core/i2da_emit.sv]
// ----------------------------------------------------------------------------
// i2da_emit
// Character sequencer: emits the sign if negative, skips leading zero digits
// and sends one ASCII digit per cycle unless stalled, via an output register.
// ----------------------------------------------------------------------------
`include "int_to_decimal_ascii_assert.svh"

module i2da_emit
  import i2da_pkg::*;
#(
  parameter int NUM_DIGITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  conv_res_t               res,
  input  logic [4*NUM_DIGITS-1:0] bcd,
  output logic                    take,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              char_code,
  output logic                    last_char
);

  localparam int BCD_W = 4 * NUM_DIGITS;
  localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  emit_state_t      state_r, state_nxt;
  logic [BCD_W-1:0] digits_r, digits_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             last_r, last_nxt;
  logic [3:0]       top;
  logic             slot_free;

  assign top       = digits_r[BCD_W-1 -: 4];
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      EM_IDLE: begin
        if (res.valid) state_nxt = res.negative ? EM_SIGN : EM_SKIP;
      end
      EM_SIGN: begin
        if (slot_free) state_nxt = EM_SKIP;
      end
      EM_SKIP: begin
        if (top != 4'd0 || idx_r == '0) state_nxt = EM_DIGIT;
      end
      EM_DIGIT: begin
        if (slot_free && idx_r == '0) state_nxt = EM_IDLE;
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_comb begin
    take          = 1'b0;
    digits_nxt    = digits_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    char_nxt      = char_r;
    last_nxt      = last_r;
    case (state_r)
      EM_IDLE: begin
        take = res.valid;
        if (res.valid) begin
          digits_nxt = bcd;
          idx_nxt    = IDX_W'(NUM_DIGITS - 1);
        end
      end
      EM_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = CHAR_MINUS;
          last_nxt      = 1'b0;
        end
      end
      EM_SKIP: begin
        if (top == 4'd0 && idx_r != '0) begin
          digits_nxt = digits_r << 4;
          idx_nxt    = idx_r - IDX_W'(1);
        end
      end
      EM_DIGIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = CHAR_ZERO + {4'd0, top};
          last_nxt      = (idx_r == '0);
          digits_nxt    = digits_r << 4;
          if (idx_r != '0) idx_nxt = idx_r - IDX_W'(1);
        end
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    digits_r <= digits_nxt;
    idx_r    <= idx_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid = out_valid_r;
  assign char_code = char_r;
  assign last_char = last_r;

  `I2DA_ASSERT_NOW(a_char_legal, out_valid_r, (char_r == CHAR_MINUS) || ((char_r >= CHAR_ZERO) && (char_r <= CHAR_NINE)), "illegal character code")
  `I2DA_ASSERT_NOW(a_minus_not_last, out_valid_r && (char_r == CHAR_MINUS), !last_r, "sign flagged as last character")
  `I2DA_ASSERT_NEXT(a_res_held, res.valid && !take, res.valid && $stable(bcd), "converter result dropped before take")

endmodule

[rtl/core/int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed integer to decimal ASCII text, most significant character first.
// ----------------------------------------------------------------------------
// Each input transaction carries one VALUE_WIDTH-bit two's complement value
// and yields its decimal text on the result channel, one character per
// transaction: '-' first for a negative value, then the digits without
// leading zeros ('0' alone for zero), with last_char set on the final one.
// The most negative value converts to its full magnitude. A shift-and-add-3
// converter takes one magnitude bit per cycle; the character sequencer then
// sends the text while the next value converts, so with the result side
// always ready the converter sets the sustained rate.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii
  import i2da_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  i2da_in_if.sink    in_ch,
  i2da_out_if.source out_ch
);

  localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;

  conv_res_t               res;
  logic [4*NUM_DIGITS-1:0] bcd;
  logic                    take;

  i2da_bcd_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .value    (in_ch.value),
    .res      (res),
    .bcd      (bcd),
    .take     (take)
  );

  i2da_emit #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .bcd       (bcd),
    .take      (take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .char_code (out_ch.char_code),
    .last_char (out_ch.last_char)
  );

endmodule

[sim/i2da_text_checker.sv]
// ----------------------------------------------------------------------------
// i2da_text_checker
// Watches both channels of the decimal ASCII converter. Every accepted input
// value is expanded into the characters of its decimal text; every accepted
// output character is compared against the oldest pending one.
// ----------------------------------------------------------------------------
module i2da_text_checker
  import i2da_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  i2da_in_if   in_mon,
  i2da_out_if  out_mon,
  output int   mismatches,
  output int   chars_pending,
  output int   chars_checked
);

  localparam logic [31:0] RADIX      = 32'd10;
  localparam int          MAX_DIGITS = 10;
  localparam int          REPORT_MAX = 10;

  typedef struct {
    logic signed [31:0] source;
    logic [7:0]         code;
    logic               last;
  } text_char_t;

  text_char_t expected_chars[$];
  int         fail_total;
  int         seen_total;

  function automatic void push_char(logic signed [31:0] src, logic [7:0] code, logic last);
    text_char_t c;
    c.source = src;
    c.code   = code;
    c.last   = last;
    expected_chars = {expected_chars, c};
  endfunction

  function automatic void predict_text(logic signed [31:0] v);
    logic [31:0] mag;
    logic [3:0]  digits[MAX_DIGITS];
    int          n;
    n   = 0;
    mag = v[31] ? (~v + 32'd1) : v;
    do begin
      digits[n] = 4'(mag % RADIX);
      mag       = mag / RADIX;
      n++;
    end while (mag != 0);
    if (v[31]) begin
      push_char(v, CHAR_MINUS, 1'b0);
    end
    for (int i = n - 1; i >= 0; i--) begin
      push_char(v, CHAR_ZERO + 8'(digits[i]), i == 0);
    end
  endfunction

  initial begin
    fail_total    = 0;
    seen_total    = 0;
    mismatches    = 0;
    chars_pending = 0;
    chars_checked = 0;
  end

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        seen_total++;
        if (expected_chars.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_MAX) begin
            $display("[%0t] unexpected character: code %0d last %0b, nothing pending",
                     $realtime, out_mon.char_code, out_mon.last_char);
          end
        end else begin
          want = expected_chars.pop_front();
          if (out_mon.char_code !== want.code || out_mon.last_char !== want.last) begin
            fail_total++;
            if (fail_total <= REPORT_MAX) begin
              $display("[%0t] value %0d: expected code %0d last %0b, got %0d last %0b",
                       $realtime, want.source, want.code, want.last,
                       out_mon.char_code, out_mon.last_char);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_text(in_mon.value);
      end
    end
    mismatches    <= fail_total;
    chars_pending <= expected_chars.size();
    chars_checked <= seen_total;
  end

endmodule

[sim/int_to_decimal_ascii_tb.sv]
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_tb
// Drives signed integers into the converter, directed corner values first
// and then random values of every digit length, with random idle gaps on
// the input and random back-pressure on the output. A checker beside the
// block predicts the decimal text and compares every character.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_tb;

  localparam int VALUE_WIDTH    = 32;
  localparam int RANDOM_ITEMS   = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int MAX_WAIT       = 9;
  localparam int STEADY_SPAN    = 50;

  typedef enum int {
    VAL_FULL,
    VAL_SMALL,
    VAL_SHORT,
    VAL_DECADE
  } value_class_t;

  logic clk;
  logic rst_n;
  logic steady;
  int   mismatches;
  int   chars_pending;
  int   chars_checked;
  int   values_sent;
  int   negatives_sent;
  int   idle_cycles;

  logic signed [31:0] corner_values[] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
    32'sd2147483647, 32'h8000_0000, -32'sd2147483647, 32'sd1000000000,
    32'sd999999999, -32'sd999999999, -32'sd1000000000, 32'h5555_5555,
    32'hAAAA_AAAA, 32'sd123456789, -32'sd123456789, 32'sd4294967,
    -32'sd5, 32'sd1000000009
  };

  logic [31:0] decades[10] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
    32'd10000000, 32'd100000000, 32'd1000000000
  };

  i2da_in_if #(.WIDTH(VALUE_WIDTH)) in_bus ();
  i2da_out_if                       out_bus ();

  int_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  i2da_text_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .mismatches   (mismatches),
    .chars_pending(chars_pending),
    .chars_checked(chars_checked)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [31:0] make_value();
    value_class_t cls;
    logic [31:0]  v;
    cls = value_class_t'($urandom_range(0, 3));
    case (cls)
      VAL_FULL:   v = $urandom;
      VAL_SMALL:  v = $urandom_range(0, 99);
      VAL_SHORT:  v = $urandom >> $urandom_range(0, 31);
      default:    v = decades[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
    endcase
    if (cls != VAL_FULL && $urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  task automatic send_value(logic signed [31:0] v);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.value <= v;
    do @(posedge clk); while (!in_bus.ready);
    values_sent++;
    if (v < 0) begin
      negatives_sent++;
    end
  endtask

  // result side: random back-pressure per character
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d characters pending",
               WATCHDOG_LIMIT, chars_pending);
      $display("int_to_decimal_ascii_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    steady         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.value   = '0;
    values_sent    = 0;
    negatives_sent = 0;
    idle_cycles    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_values[i]) begin
      send_value(corner_values[i]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = ((n / STEADY_SPAN) % 4) == 3;
      send_value(make_value());
    end
    steady = 1'b0;
    in_bus.valid <= 1'b0;

    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("converted %0d values (%0d negative) into %0d checked characters",
             values_sent, negatives_sent, chars_checked);
    $display("input gaps and output stalls of 0..%0d cycles, with stall-free stretches",
             MAX_WAIT);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("int_to_decimal_ascii_tb: PASS");
    end else begin
      $display("int_to_decimal_ascii_tb: FAIL");
    end
    $finish;
  end

endmodule

[int_to_decimal_ascii.f]
+incdir+rtl/core
rtl/core/i2da_pkg.sv
rtl/core/i2da_in_if.sv
rtl/core/i2da_out_if.sv
rtl/core/i2da_bcd_conv.sv
rtl/core/i2da_emit.sv
rtl/core/int_to_decimal_ascii.sv
sim/i2da_text_checker.sv
sim/int_to_decimal_ascii_tb.sv
